/* rtl/lcp_pkg.sv */
package lcp_pkg;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_SCALE = 8'b0000_0100,
    ST_DIV1  = 8'b0000_1000,
    ST_PD    = 8'b0001_0000,
    ST_SAT   = 8'b0010_0000,
    ST_DIV2  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } lcp_state_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SPEED = 3'd6;

  // register reset values
  localparam logic [11:0] RST_THRESHOLD = 12'd2400;
  localparam logic [11:0] RST_VALUE_CAP = 12'd1400;
  localparam logic [7:0] RST_PROP_GAIN = 8'd35;
  localparam logic [9:0] RST_DERIV_GAIN = 10'd120;
  localparam logic [9:0] RST_BASE_SPEED = 10'd200;
  localparam logic [9:0] RST_CONTROL_LIMIT = 10'd400;
  localparam logic [9:0] RST_SEARCH_SPEED = 10'd200;

  // field layout
  localparam int unsigned SENS_W = 12;
  localparam int unsigned FIELD_COUNT = 5;
  localparam int unsigned DRIVE_W = 12;

  // shared serial divider: quotient always below 2**QUO_W
  localparam int unsigned DVD_W = 26;
  localparam int unsigned DVS_W = 16;
  localparam int unsigned QUO_W = 12;
  localparam logic [DVS_W-1:0] MILLI = 16'd1000;

  // pd accumulator and number of gain bits walked serially
  localparam int unsigned ACC_W = 25;
  localparam int unsigned PD_STEPS = 10;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } lcp_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } lcp_div_rsp_t;

endpackage

/* rtl/lcp_div.sv */
module lcp_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcp_pkg::lcp_div_req_t req_i,
  output lcp_pkg::lcp_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(lcp_pkg::QUO_W + 1);

  logic [lcp_pkg::DVS_W-1:0] rem_q, rem_d;
  logic [lcp_pkg::DVS_W-1:0] dvs_q, dvs_d;
  logic [lcp_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [lcp_pkg::DVS_W:0]   trial;
  logic [lcp_pkg::DVS_W:0]   trial_sub;
  logic                      fits;

  // one restoring step: bring down the next dividend bit
  assign trial     = {rem_q, quo_q[lcp_pkg::QUO_W-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // upper part is already below the divisor as the quotient fits QUO_W bits
      rem_d = lcp_pkg::DVS_W'(req_i.dividend[lcp_pkg::DVD_W-1:lcp_pkg::QUO_W]);
      quo_d = req_i.dividend[lcp_pkg::QUO_W-1:0];
      dvs_d = req_i.divisor;
      cnt_d = CNT_W'(lcp_pkg::QUO_W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? trial_sub[lcp_pkg::DVS_W-1:0] : trial[lcp_pkg::DVS_W-1:0];
      quo_d = {quo_q[lcp_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/line_centroid_pd_steering.sv */
// PD line follower on a centroid of up to five IR samples. Each scan word
// carries five 12 bit samples; each is inverted against the threshold,
// clamped to the value cap, and a weighted centroid (weights 0..4000) gives
// the error in thousandths around the centre. The steering correction is
// kp*e + kd*(e - last e), bounded by +-control_limit*1000 and scaled down by
// 1000 toward zero; the wheels get the negated base +- correction. A scan
// with no line gives a search spin toward the side of the last error and
// sets tuser. One scan is worked on at a time. The time a scan with a line
// takes is set by the one-sample per cycle scan, the 12 step restoring
// divider shared by the centroid and the scaling by 1000, and the 10 step
// bit-serial gain multiply. A result waits in the output register while
// the next scan is taken.
module line_centroid_pd_steering #(
  parameter int unsigned NUM_SENSORS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [lcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // scan words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, 4'b0
  // drive words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // left_drive, right_drive
  output logic        m_axis_tuser   // line_lost
);

  localparam int unsigned NUSED = (NUM_SENSORS < lcp_pkg::FIELD_COUNT) ?
                                  NUM_SENSORS : lcp_pkg::FIELD_COUNT;
  localparam int unsigned IDX_W = $clog2(NUSED);
  localparam int unsigned CENTRE = (NUM_SENSORS - 1) * 500;
  localparam int unsigned ERR_WW = 14;
  localparam int unsigned PD_CNT_W = $clog2(lcp_pkg::PD_STEPS);
  localparam int unsigned MAG_W = 20;
  localparam int unsigned SUM_W = 16;

  lcp_pkg::lcp_state_e state_q, state_d;

  // configuration registers
  logic [11:0] threshold_q, value_cap_q;
  logic [7:0]  prop_gain_q;
  logic [9:0]  deriv_gain_q, base_speed_q, control_limit_q, search_speed_q;

  // scan datapath
  logic [lcp_pkg::SENS_W-1:0] sens_q [NUSED];
  logic [lcp_pkg::SENS_W-1:0] sens_d [NUSED];
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic [SUM_W-1:0]           wsum_q, wsum_d;
  logic [11:0]                inv_raw, inv_val;
  logic                       lost_q, lost_d;

  // error and pd datapath
  logic signed [11:0]              prev_err_q, prev_err_d;
  logic signed [ERR_WW-1:0]        err_wide;
  logic signed [11:0]              err_sat;
  logic signed [12:0]              err_diff;
  logic signed [lcp_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [lcp_pkg::ACC_W-1:0] e_sh_q, e_sh_d;
  logic signed [lcp_pkg::ACC_W-1:0] diff_sh_q, diff_sh_d;
  logic [lcp_pkg::PD_STEPS-1:0]    kp_sh_q, kp_sh_d;
  logic [lcp_pkg::PD_STEPS-1:0]    kd_sh_q, kd_sh_d;
  logic [PD_CNT_W-1:0]             pd_cnt_q, pd_cnt_d;

  // saturation and scaling
  logic [MAG_W-1:0]                 lim_mag;
  logic signed [lcp_pkg::ACC_W-1:0] lim_pos;
  logic signed [lcp_pkg::ACC_W-1:0] num_sat;
  logic signed [lcp_pkg::ACC_W-1:0] num_abs;
  logic                             neg_q, neg_d;
  logic signed [11:0]               corr_q, corr_d;

  // output side
  logic signed [12:0] left_wide, right_wide;
  logic               out_load;
  logic               m_valid_q, m_valid_d;
  logic [23:0]        m_data_q;
  logic               m_lost_q;

  lcp_pkg::lcp_div_req_t div_req;
  lcp_pkg::lcp_div_rsp_t div_rsp;

  lcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // inverted, clamped value of the sample at the head of the shift line
  assign inv_raw = (threshold_q > sens_q[0]) ? (threshold_q - sens_q[0]) : 12'd0;
  assign inv_val = (inv_raw > value_cap_q) ? value_cap_q : inv_raw;

  // error around the centre, bounded to 12 bits
  assign err_wide = $signed({2'b00, div_rsp.quotient}) - $signed(ERR_WW'(CENTRE));
  always_comb begin
    if (err_wide > $signed(ERR_WW'(2047))) begin
      err_sat = 12'sd2047;
    end else if (err_wide < -$signed(ERR_WW'(2048))) begin
      err_sat = -12'sd2048;
    end else begin
      err_sat = err_wide[11:0];
    end
  end
  assign err_diff = 13'(err_sat) - 13'(prev_err_q);

  // correction bound
  assign lim_mag = MAG_W'(control_limit_q) * MAG_W'(1000);
  assign lim_pos = $signed({(lcp_pkg::ACC_W - MAG_W)'(0), lim_mag});
  always_comb begin
    if (acc_q > lim_pos) begin
      num_sat = lim_pos;
    end else if (acc_q < -lim_pos) begin
      num_sat = -lim_pos;
    end else begin
      num_sat = acc_q;
    end
  end
  assign num_abs = num_sat[lcp_pkg::ACC_W-1] ? -num_sat : num_sat;

  // wheel commands
  always_comb begin
    if (lost_q) begin
      if (prev_err_q > 12'sd0) begin
        left_wide = -$signed({3'b000, search_speed_q});
      end else begin
        left_wide = $signed({3'b000, search_speed_q});
      end
      right_wide = -left_wide;
    end else begin
      left_wide  = -$signed({3'b000, base_speed_q}) - 13'(corr_q);
      right_wide = 13'(corr_q) - $signed({3'b000, base_speed_q});
    end
  end

  assign out_load = (state_q == lcp_pkg::ST_EMIT) && (!m_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d    = state_q;
    sens_d     = sens_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    wsum_d     = wsum_q;
    lost_d     = lost_q;
    prev_err_d = prev_err_q;
    acc_d      = acc_q;
    e_sh_d     = e_sh_q;
    diff_sh_d  = diff_sh_q;
    kp_sh_d    = kp_sh_q;
    kd_sh_d    = kd_sh_q;
    pd_cnt_d   = pd_cnt_q;
    neg_d      = neg_q;
    corr_d     = corr_q;
    div_req    = '0;
    unique case (state_q)
      lcp_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < NUSED; i++) begin
            sens_d[i] = s_axis_tdata[i*lcp_pkg::SENS_W +: lcp_pkg::SENS_W];
          end
          idx_d   = '0;
          sum_d   = '0;
          wsum_d  = '0;
          state_d = lcp_pkg::ST_SCAN;
        end
      end
      lcp_pkg::ST_SCAN: begin
        // one sample a cycle: plain and index-weighted sums
        sum_d  = sum_q + SUM_W'(inv_val);
        wsum_d = wsum_q + SUM_W'(inv_val) * SUM_W'(idx_q);
        for (int i = 0; i < NUSED - 1; i++) begin
          sens_d[i] = sens_q[i+1];
        end
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(NUSED - 1)) begin
          lost_d  = (sum_d == '0);
          state_d = (sum_d == '0) ? lcp_pkg::ST_EMIT : lcp_pkg::ST_SCALE;
        end
      end
      lcp_pkg::ST_SCALE: begin
        div_req.start    = 1'b1;
        div_req.dividend = lcp_pkg::DVD_W'(wsum_q) * lcp_pkg::DVD_W'(1000);
        div_req.divisor  = lcp_pkg::DVS_W'(sum_q);
        state_d          = lcp_pkg::ST_DIV1;
      end
      lcp_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          prev_err_d = err_sat;
          e_sh_d     = lcp_pkg::ACC_W'(err_sat);
          diff_sh_d  = lcp_pkg::ACC_W'(err_diff);
          kp_sh_d    = lcp_pkg::PD_STEPS'(prop_gain_q);
          kd_sh_d    = deriv_gain_q;
          acc_d      = '0;
          pd_cnt_d   = '0;
          state_d    = lcp_pkg::ST_PD;
        end
      end
      lcp_pkg::ST_PD: begin
        // one gain bit a cycle for both products
        acc_d = acc_q + (kp_sh_q[0] ? e_sh_q : 25'sd0)
                      + (kd_sh_q[0] ? diff_sh_q : 25'sd0);
        e_sh_d    = e_sh_q <<< 1;
        diff_sh_d = diff_sh_q <<< 1;
        kp_sh_d   = kp_sh_q >> 1;
        kd_sh_d   = kd_sh_q >> 1;
        pd_cnt_d  = pd_cnt_q + PD_CNT_W'(1);
        if (pd_cnt_q == PD_CNT_W'(lcp_pkg::PD_STEPS - 1)) begin
          state_d = lcp_pkg::ST_SAT;
        end
      end
      lcp_pkg::ST_SAT: begin
        neg_d            = num_sat[lcp_pkg::ACC_W-1];
        div_req.start    = 1'b1;
        div_req.dividend = lcp_pkg::DVD_W'(num_abs[MAG_W-1:0]);
        div_req.divisor  = lcp_pkg::MILLI;
        state_d          = lcp_pkg::ST_DIV2;
      end
      lcp_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          corr_d  = neg_q ? -$signed({1'b0, div_rsp.quotient[10:0]})
                          : $signed({1'b0, div_rsp.quotient[10:0]});
          state_d = lcp_pkg::ST_EMIT;
        end
      end
      lcp_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = lcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcp_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == lcp_pkg::ST_IDLE);

  // output register valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= lcp_pkg::ST_IDLE;
      m_valid_q       <= 1'b0;
      prev_err_q      <= '0;
      lost_q          <= 1'b0;
      threshold_q     <= lcp_pkg::RST_THRESHOLD;
      value_cap_q     <= lcp_pkg::RST_VALUE_CAP;
      prop_gain_q     <= lcp_pkg::RST_PROP_GAIN;
      deriv_gain_q    <= lcp_pkg::RST_DERIV_GAIN;
      base_speed_q    <= lcp_pkg::RST_BASE_SPEED;
      control_limit_q <= lcp_pkg::RST_CONTROL_LIMIT;
      search_speed_q  <= lcp_pkg::RST_SEARCH_SPEED;
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      prev_err_q <= prev_err_d;
      lost_q     <= lost_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lcp_pkg::CFG_THRESHOLD:     threshold_q     <= cfg_data_i[11:0];
          lcp_pkg::CFG_VALUE_CAP:     value_cap_q     <= cfg_data_i[11:0];
          lcp_pkg::CFG_PROP_GAIN:     prop_gain_q     <= cfg_data_i[7:0];
          lcp_pkg::CFG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i[9:0];
          lcp_pkg::CFG_BASE_SPEED:    base_speed_q    <= cfg_data_i[9:0];
          lcp_pkg::CFG_CONTROL_LIMIT: control_limit_q <= cfg_data_i[9:0];
          lcp_pkg::CFG_SEARCH_SPEED:  search_speed_q  <= cfg_data_i[9:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sens_q    <= sens_d;
    idx_q     <= idx_d;
    sum_q     <= sum_d;
    wsum_q    <= wsum_d;
    acc_q     <= acc_d;
    e_sh_q    <= e_sh_d;
    diff_sh_q <= diff_sh_d;
    kp_sh_q   <= kp_sh_d;
    kd_sh_q   <= kd_sh_d;
    pd_cnt_q  <= pd_cnt_d;
    neg_q     <= neg_d;
    corr_q    <= corr_d;
    if (out_load) begin
      m_data_q <= {right_wide[11:0], left_wide[11:0]};
      m_lost_q <= lost_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_lost_q;

endmodule

/* rtl/lcp_chk.sv */
module lcp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a waiting drive word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("drive word changed while stalled");

  // one scan at a time
  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("scan taken while another is in work");

  // no drive word in the cycle after a scan is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("drive word appeared too early");

  // search spin drives the wheels in opposite directions
  a_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[11:0] + m_axis_tdata[23:12]) == 12'd0)
    else $error("search spin not symmetric");

  // tracking: left plus right is minus twice the base, always even
  a_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !(m_axis_tdata[0] ^ m_axis_tdata[12]))
    else $error("wheel commands not around a common base");

endmodule

bind line_centroid_pd_steering lcp_chk u_lcp_chk (.*);
